@@ rtl/rspe_pkg.sv @@
// rspe_pkg: shared constants, types and field arithmetic for the parity encoder
`timescale 1ns / 1ps

package rspe_pkg;

  localparam int PARITY_COUNT = 10;
  localparam int BYTE_W       = 8;
  localparam int IDX_W        = 4;
  localparam int CNT_W        = $clog2(PARITY_COUNT + 1);

  localparam logic [BYTE_W:0] FIELD_POLY = 9'h11D;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // generator coefficients, front of the register first
  localparam byte_t GEN_COEF [PARITY_COUNT] = '{
    8'd196, 8'd35, 8'd39, 8'd119, 8'd235, 8'd215, 8'd231, 8'd226, 8'd93, 8'd23
  };

  // per-cycle controls shared by every cell of the chain
  typedef struct packed {
    logic absorb;  // message beat taken: work bytes step
    logic load;    // last message beat: finished parity moves to the hold bytes
    logic shift;   // parity beat taken: hold bytes move one place to the front
  } cell_ctrl_t;

  // shift-and-add product in GF(256)
  function automatic byte_t gf_mul(input byte_t x, input byte_t y);
    logic [BYTE_W:0] a;
    byte_t           acc;
    a   = {1'b0, x};
    acc = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (y[k]) begin
        acc = acc ^ a[BYTE_W-1:0];
      end
      a = {a[BYTE_W-1:0], 1'b0};
      if (a[BYTE_W]) begin
        a = a ^ FIELD_POLY;
      end
    end
    return acc;
  endfunction

endpackage

@@ rtl/rspe_ifs.sv @@
// rspe_ifs: message and parity channel interfaces
`timescale 1ns / 1ps

interface rspe_in_if
  import rspe_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface rspe_out_if
  import rspe_pkg::*;
();
  logic             valid;
  logic             ready;
  byte_t            parity_byte;
  logic [IDX_W-1:0] parity_index;
  logic             final_parity;

  modport source (output valid, output parity_byte, output parity_index,
                  output final_parity, input ready);
  modport sink (input valid, input parity_byte, input parity_index,
                input final_parity, output ready);
endinterface

@@ rtl/rspe_cell.sv @@
// rspe_cell: one stage of the division register with its parity hold byte
`timescale 1ns / 1ps

module rspe_cell
  import rspe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  byte_t      coef,
  input  byte_t      fb,
  input  byte_t      work_in,   // work byte of the next cell back
  input  byte_t      hold_in,   // hold byte of the next cell back
  output byte_t      work_out,
  output byte_t      hold_out
);

  byte_t work_r, work_nxt;
  byte_t hold_r, hold_nxt;
  byte_t step_val;

  assign step_val = work_in ^ gf_mul(coef, fb);

  always_comb begin
    work_nxt = work_r;
    hold_nxt = hold_r;
    if (ctrl.load) begin
      hold_nxt = step_val;
      work_nxt = '0;
    end else begin
      if (ctrl.absorb) begin
        work_nxt = step_val;
      end
      if (ctrl.shift) begin
        hold_nxt = hold_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r <= '0;
    end else begin
      work_r <= work_nxt;
    end
  end

  // hold bytes only matter while the drain count is non-zero
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  assign work_out = work_r;
  assign hold_out = hold_r;

endmodule

@@ rtl/reed_solomon_parity_encoder.sv @@
// reed_solomon_parity_encoder: systematic RS(GF256) parity generator, ten parity bytes
//
// usage
//   in_ch  : one message byte per beat, end_of_message set on the final byte
//   out_ch : ten parity beats per message, index 0 first, final_parity on index 9
// structure
//   a row of ten cells; each keeps one byte of the division register and one
//   byte of finished parity. the feedback byte (message byte xor front work
//   byte) goes to every cell, which adds its constant gf product to the byte
//   handed on by its neighbour behind it
// timing
//   a message byte is absorbed in the cycle it is taken, one byte per cycle while in_ch.ready stays high
//   the first parity beat is valid the cycle after the final message byte;
//   the run then continues without gaps when the receiver never stalls
//   message bytes of the next message are taken while parity still drains;
//   only a final byte waits until the hold bytes are free (the last parity
//   beat of the previous run going out in that same cycle is enough)
// reset
//   rst_n (synchronous) clears the division register and drops any parity run
// stalls
//   with out_ch.ready low the current parity beat holds steady

module reed_solomon_parity_encoder
  import rspe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rspe_in_if.sink           in_ch,
  rspe_out_if.source        out_ch
);

  cell_ctrl_t ctrl;
  cnt_t       left_r, left_nxt;     // parity beats still to deliver
  byte_t      fb;
  logic       hold_free;
  logic       in_beat;
  logic       out_beat;

  byte_t work_w [PARITY_COUNT+1];
  byte_t hold_w [PARITY_COUNT+1];

  // the back end of the chain feeds zeros
  assign work_w[PARITY_COUNT] = '0;
  assign hold_w[PARITY_COUNT] = '0;

  assign out_beat  = out_ch.valid & out_ch.ready;
  assign hold_free = (left_r == '0) | ((left_r == cnt_t'(1)) & out_ch.ready);
  assign in_ch.ready = hold_free | ~in_ch.end_of_message;
  assign in_beat   = in_ch.valid & in_ch.ready;

  // feedback from the front work byte
  assign fb = in_ch.data_byte ^ work_w[0];

  assign ctrl.absorb = in_beat;
  assign ctrl.load   = in_beat & in_ch.end_of_message;
  assign ctrl.shift  = out_beat;

  for (genvar i = 0; i < PARITY_COUNT; i++) begin : g_cell
    rspe_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .coef     (GEN_COEF[i]),
      .fb       (fb),
      .work_in  (work_w[i+1]),
      .hold_in  (hold_w[i+1]),
      .work_out (work_w[i]),
      .hold_out (hold_w[i])
    );
  end

  // drain count
  always_comb begin
    left_nxt = left_r;
    if (ctrl.load) begin
      left_nxt = cnt_t'(PARITY_COUNT);
    end else if (out_beat) begin
      left_nxt = left_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  assign out_ch.valid        = (left_r != '0);
  assign out_ch.parity_byte  = hold_w[0];
  assign out_ch.parity_index = IDX_W'(cnt_t'(PARITY_COUNT) - left_r);
  assign out_ch.final_parity = (left_r == cnt_t'(1));

endmodule

@@ rtl/rspe_checker.sv @@
// rspe_checker: port-level assertions for the parity encoder, bound to the top level
`timescale 1ns / 1ps

module rspe_checker
  import rspe_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_end_of_message,
  input logic             out_valid,
  input logic             out_ready,
  input byte_t            out_parity_byte,
  input logic [IDX_W-1:0] out_parity_index,
  input logic             out_final_parity
);

  logic in_last_beat;
  logic out_beat;

  assign in_last_beat = in_valid & in_ready & in_end_of_message;
  assign out_beat     = out_valid & out_ready;

  // a stalled parity beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_parity_byte)
      && $stable(out_parity_index) && $stable(out_final_parity))
    else $error("parity beat changed while stalled");

  // parity starts the cycle after the final message byte, at index 0
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_last_beat |=> out_valid && out_parity_index == '0)
    else $error("parity run did not start after final byte");

  // the run is ten beats without gaps, index counting up
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && !out_final_parity |=>
      out_valid && out_parity_index == $past(out_parity_index) + 1'b1)
    else $error("parity run broke off");

  // final flag only on the last index
  a_final_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_parity |-> out_parity_index == IDX_W'(PARITY_COUNT - 1))
    else $error("final parity on wrong index");

  // a final byte never overruns a parity run still in progress
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_last_beat && out_valid |-> out_ready && out_final_parity)
    else $error("final byte taken over undrained parity");

endmodule

bind reed_solomon_parity_encoder rspe_checker u_rspe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_end_of_message (in_ch.end_of_message),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_parity_byte   (out_ch.parity_byte),
  .out_parity_index  (out_ch.parity_index),
  .out_final_parity  (out_ch.final_parity)
);

@@ sim/tb_reed_solomon_parity_encoder.sv @@
// tb_reed_solomon_parity_encoder: self-checking bench for the gf(256) parity encoder
`timescale 1ns / 1ps

module tb_reed_solomon_parity_encoder;
  import rspe_pkg::*;

  typedef logic [PARITY_COUNT*BYTE_W-1:0] parity_set_t;

  typedef struct packed {
    byte_t            value;
    logic [IDX_W-1:0] pos;
    logic             last;
  } parity_beat_t;

  typedef struct packed {
    byte_t       data;
    logic        eom;
    logic        typed;  // want holds the hand-written parity for this row
    parity_set_t want;
  } dir_row_t;

  // generator coefficients, front of the division register first
  localparam byte_t DIV_COEF [PARITY_COUNT] = '{
    8'hC4, 8'h23, 8'h27, 8'h77, 8'hEB, 8'hD7, 8'hE7, 8'hE2, 8'h5D, 8'h17
  };

  localparam parity_set_t ALL_ZERO  = '0;
  localparam parity_set_t UNIT_RUN  = 80'hC4_23_27_77_EB_D7_E7_E2_5D_17;
  localparam int          DIR_N     = 21;
  localparam int          BYTES_TARGET = 370;

  localparam dir_row_t DIRECTED_ROWS [DIR_N] = '{
    '{8'h00, 1'b1, 1'b1, ALL_ZERO},   // zero byte straight after reset
    '{8'h01, 1'b1, 1'b1, UNIT_RUN},   // unit feedback gives the coefficients
    '{8'hFF, 1'b1, 1'b0, ALL_ZERO},
    '{8'h00, 1'b0, 1'b0, ALL_ZERO},
    '{8'h00, 1'b0, 1'b0, ALL_ZERO},
    '{8'h00, 1'b1, 1'b1, ALL_ZERO},   // all-zero message
    '{8'h01, 1'b0, 1'b0, ALL_ZERO},
    '{8'h00, 1'b1, 1'b0, ALL_ZERO},
    '{8'hFF, 1'b0, 1'b0, ALL_ZERO},
    '{8'hFF, 1'b0, 1'b0, ALL_ZERO},
    '{8'hFF, 1'b0, 1'b0, ALL_ZERO},
    '{8'hFF, 1'b1, 1'b0, ALL_ZERO},
    '{8'h80, 1'b0, 1'b0, ALL_ZERO},
    '{8'h7F, 1'b0, 1'b0, ALL_ZERO},
    '{8'h55, 1'b0, 1'b0, ALL_ZERO},
    '{8'hAA, 1'b0, 1'b0, ALL_ZERO},
    '{8'h01, 1'b1, 1'b0, ALL_ZERO},
    '{8'h01, 1'b1, 1'b1, UNIT_RUN},   // register must be clear after a run
    '{8'h00, 1'b1, 1'b1, ALL_ZERO},
    '{8'h5A, 1'b0, 1'b0, ALL_ZERO},
    '{8'hC3, 1'b1, 1'b0, ALL_ZERO}
  };

  logic clk;
  logic rst_n;

  rspe_in_if  in_ch ();
  rspe_out_if out_ch ();

  reed_solomon_parity_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  byte_t        div_reg [PARITY_COUNT];
  parity_beat_t pending_parity [$];
  int unsigned  errors;
  int unsigned  bytes_sent;
  int unsigned  messages_sent;
  int unsigned  beats_checked;
  bit           tx_calm;
  bit           rx_calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic byte_t gf_product(input byte_t a, input byte_t b);
    byte_t p;
    byte_t m;
    p = '0;
    m = a;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) p = p ^ m;
      m = {m[BYTE_W-2:0], 1'b0} ^ (m[BYTE_W-1] ? FIELD_POLY[BYTE_W-1:0] : 8'h00);
    end
    return p;
  endfunction

  // one step of the division register; returns 1 with the finished parity on a last byte
  function automatic bit absorb_byte(input byte_t data, input bit eom, output parity_set_t run);
    byte_t fb;
    fb = data ^ div_reg[0];
    for (int j = 0; j < PARITY_COUNT - 1; j++) begin
      div_reg[j] = div_reg[j+1] ^ gf_product(DIV_COEF[j], fb);
    end
    div_reg[PARITY_COUNT-1] = gf_product(DIV_COEF[PARITY_COUNT-1], fb);
    run = '0;
    if (!eom) return 1'b0;
    for (int j = 0; j < PARITY_COUNT; j++) begin
      run[(PARITY_COUNT-1-j)*BYTE_W +: BYTE_W] = div_reg[j];
      div_reg[j] = '0;
    end
    return 1'b1;
  endfunction

  task automatic send_beat(input byte_t data, input bit eom, input bit typed,
                           input parity_set_t want);
    int unsigned  gap;
    parity_set_t  run;
    parity_beat_t pb;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= data;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    if (absorb_byte(data, eom, run)) begin
      messages_sent++;
      if (typed) run = want;
      for (int j = 0; j < PARITY_COUNT; j++) begin
        pb.value = run[(PARITY_COUNT-1-j)*BYTE_W +: BYTE_W];
        pb.pos   = IDX_W'(j);
        pb.last  = (j == PARITY_COUNT - 1);
        pending_parity.push_back(pb);
      end
    end
  endtask

  // parity side: random stall before each beat, with calm stretches
  initial begin
    int unsigned stall;
    int unsigned calm_left;
    out_ch.ready <= 1'b0;
    calm_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm_left == 0) begin
        rx_calm   = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(5, 40);
      end
      calm_left--;
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    parity_beat_t exp_beat;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_parity.size() == 0) begin
        errors++;
        $display("%0t: parity beat with none expected, actual byte %0d index %0d final %0b",
                 $time, out_ch.parity_byte, out_ch.parity_index, out_ch.final_parity);
      end else begin
        exp_beat = pending_parity.pop_front();
        beats_checked++;
        if (out_ch.parity_byte !== exp_beat.value) begin
          errors++;
          $display("%0t: parity_byte mismatch, expected %0d actual %0d",
                   $time, exp_beat.value, out_ch.parity_byte);
        end
        if (out_ch.parity_index !== exp_beat.pos) begin
          errors++;
          $display("%0t: parity_index mismatch, expected %0d actual %0d",
                   $time, exp_beat.pos, out_ch.parity_index);
        end
        if (out_ch.final_parity !== exp_beat.last) begin
          errors++;
          $display("%0t: final_parity mismatch, expected %0b actual %0b",
                   $time, exp_beat.last, out_ch.final_parity);
        end
      end
    end
  end

  initial begin
    int unsigned msg_len;
    byte_t       data;
    errors        = 0;
    bytes_sent    = 0;
    messages_sent = 0;
    beats_checked = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    for (int j = 0; j < PARITY_COUNT; j++) div_reg[j] = '0;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.data_byte      <= '0;
    in_ch.end_of_message <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      send_beat(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].eom, DIRECTED_ROWS[r].typed,
                DIRECTED_ROWS[r].want);
    end

    // random messages: mostly short, now and then a long one
    while (bytes_sent < BYTES_TARGET) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
      for (int k = 0; k < msg_len; k++) begin
        data = byte_t'($urandom_range(0, 255));
        send_beat(data, (k == msg_len - 1), 1'b0, ALL_ZERO);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_parity.size() != 0) @(posedge clk);
    repeat (PARITY_COUNT + 16) @(posedge clk);

    $display("run covered %0d message bytes in %0d messages (%0d directed rows)",
             bytes_sent, messages_sent, DIR_N);
    $display("%0d parity beats compared against the predicted division register",
             beats_checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timed out with %0d parity beats still expected", $time,
             pending_parity.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
